### sv/piq_pkg.sv
// ----------------------------------------------------------------------------
// piq_pkg: shared types and constants for the point-in-quad hit test
// Coordinate width, payload words for both directions and the sorted-corner
// bundle that passes from corner selection to the cross-product stage.
// ----------------------------------------------------------------------------
`default_nettype none

package piq_pkg;

	// coordinate width, two's complement
	localparam int COORD_WIDTH = 16;
	// edge vector component: difference of two coordinates
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	// exact product of a pair of edge vector components
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
	// number of quad corners
	localparam int NUM_CORNERS = 4;
	// corners needed on each side of the query line
	localparam int SPLIT_COUNT = 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} piq_pt_t;

	// input word
	typedef struct packed {
		coord_t query_x;
		coord_t query_y;
		coord_t corner_a_x;
		coord_t corner_a_y;
		coord_t corner_b_x;
		coord_t corner_b_y;
		coord_t corner_c_x;
		coord_t corner_c_y;
		coord_t corner_d_x;
		coord_t corner_d_y;
	} piq_item_t;

	// result word
	typedef struct packed {
		logic inside_res;
		logic malformed;
	} piq_result_t;

	// corners sorted into lower-left, lower-right, upper-left, upper-right
	typedef struct packed {
		logic    malformed;
		piq_pt_t ll;
		piq_pt_t lr;
		piq_pt_t ul;
		piq_pt_t ur;
	} piq_quad_t;

endpackage

`default_nettype wire

### sv/piq_select.sv
// ----------------------------------------------------------------------------
// piq_select: corner classification and ordering
// Splits the four corners into upper and lower pairs against the query y,
// flags a split that is not two and two, and orders each pair by x.
// ----------------------------------------------------------------------------
`default_nettype none

module piq_select (
	input  wire piq_pkg::piq_item_t item,
	output piq_pkg::piq_quad_t      quad
);

	piq_pkg::piq_pt_t                     corner [piq_pkg::NUM_CORNERS];
	logic [piq_pkg::NUM_CORNERS-1:0]      upper;
	piq_pkg::piq_pt_t                     up0, up1, dn0, dn1;
	logic                                 got_up, got_dn;

	// gather corners in a, b, c, d order
	assign corner[0] = '{x: item.corner_a_x, y: item.corner_a_y};
	assign corner[1] = '{x: item.corner_b_x, y: item.corner_b_y};
	assign corner[2] = '{x: item.corner_c_x, y: item.corner_c_y};
	assign corner[3] = '{x: item.corner_d_x, y: item.corner_d_y};

	// classify: strictly above the query counts as upper
	always_comb begin
		for (int i = 0; i < piq_pkg::NUM_CORNERS; i++) begin
			upper[i] = corner[i].y > item.query_y;
		end
	end

	// pick the first and second corner of each class, keeping input order
	always_comb begin
		up0    = corner[0];
		up1    = corner[0];
		dn0    = corner[0];
		dn1    = corner[0];
		got_up = 1'b0;
		got_dn = 1'b0;
		for (int i = 0; i < piq_pkg::NUM_CORNERS; i++) begin
			if (upper[i]) begin
				if (!got_up) begin
					up0    = corner[i];
					got_up = 1'b1;
				end else begin
					up1 = corner[i];
				end
			end else begin
				if (!got_dn) begin
					dn0    = corner[i];
					got_dn = 1'b1;
				end else begin
					dn1 = corner[i];
				end
			end
		end
	end

	// order pairs by x: lower tie goes left to the later corner,
	// upper tie goes left to the earlier corner
	always_comb begin
		quad.malformed = $countones(upper) != piq_pkg::SPLIT_COUNT;
		if (dn0.x < dn1.x) begin
			quad.ll = dn0;
			quad.lr = dn1;
		end else begin
			quad.ll = dn1;
			quad.lr = dn0;
		end
		if (up0.x > up1.x) begin
			quad.ur = up0;
			quad.ul = up1;
		end else begin
			quad.ur = up1;
			quad.ul = up0;
		end
	end

endmodule

`default_nettype wire

### sv/point_in_quad_hit_test_core.sv
// ----------------------------------------------------------------------------
// point_in_quad_hit_test_core: point-in-convex-quad hit test
// Channel  | Signals                       | Handshake
// ---------+-------------------------------+-----------------------------------
// input    | start, busy, item (piq_item_t)| word taken when start && !busy
// result   | strobe, result (piq_result_t) | word valid for the strobe cycle
//
// One word is accepted every cycle; busy is never raised.
// Each word passes the input register, product register and result register in turn.
// The left and right edge cross products come from four products in the product
// stage, one multiplier each; the compare and final decision fill the result stage.
// arst_n clears the valid bits of every stage; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_quad_hit_test_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire piq_pkg::piq_item_t item,
	output logic                  strobe,
	output piq_pkg::piq_result_t  result
);

	localparam int DW = piq_pkg::DIFF_WIDTH;
	localparam int PW = piq_pkg::PROD_WIDTH;

	logic                 valid_s1;
	piq_pkg::piq_item_t   item_s1;
	piq_pkg::piq_quad_t   quad;
	piq_pkg::piq_pt_t     q;

	logic signed [DW-1:0] l_bx, l_cy, l_by, l_cx;
	logic signed [DW-1:0] r_bx, r_cy, r_by, r_cx;
	logic        [PW-1:0] prod_l1, prod_l2, prod_r1, prod_r2;

	logic                 valid_s2;
	logic                 malformed_s2;
	logic        [PW-1:0] prod_l1_s2, prod_l2_s2, prod_r1_s2, prod_r2_s2;

	logic                 left_of_l, left_of_r;
	logic                 strobe_q;
	piq_pkg::piq_result_t result_q;

	// difference of two coordinates, one bit wider
	function automatic logic signed [DW-1:0] diff(input piq_pkg::coord_t a,
		input piq_pkg::coord_t b);
		diff = {a[piq_pkg::COORD_WIDTH-1], a} - {b[piq_pkg::COORD_WIDTH-1], b};
	endfunction

	// exact signed product of two differences
	function automatic logic [PW-1:0] mul(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		mul = {{DW{a[DW-1]}}, a} * {{DW{b[DW-1]}}, b};
	endfunction

	assign busy = 1'b0;

	// input register: capture every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// sort corners into the left and right edges
	piq_select u_select (
		.item (item_s1),
		.quad (quad)
	);

	assign q = '{x: item_s1.query_x, y: item_s1.query_y};

	// edge vectors: left edge ll -> ul, right edge lr -> ur, both against q
	assign l_bx = diff(quad.ul.x, quad.ll.x);
	assign l_by = diff(quad.ul.y, quad.ll.y);
	assign l_cx = diff(q.x, quad.ll.x);
	assign l_cy = diff(q.y, quad.ll.y);
	assign r_bx = diff(quad.ur.x, quad.lr.x);
	assign r_by = diff(quad.ur.y, quad.lr.y);
	assign r_cx = diff(q.x, quad.lr.x);
	assign r_cy = diff(q.y, quad.lr.y);

	assign prod_l1 = mul(l_bx, l_cy);
	assign prod_l2 = mul(l_by, l_cx);
	assign prod_r1 = mul(r_bx, r_cy);
	assign prod_r2 = mul(r_by, r_cx);

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			malformed_s2 <= quad.malformed;
			prod_l1_s2   <= prod_l1;
			prod_l2_s2   <= prod_l2;
			prod_r1_s2   <= prod_r1;
			prod_r2_s2   <= prod_r2;
		end
	end

	// strictly-left tests from the cross product sign
	assign left_of_l = $signed(prod_l1_s2) > $signed(prod_l2_s2);
	assign left_of_r = $signed(prod_r1_s2) > $signed(prod_r2_s2);

	// result register: one strobe per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			result_q.malformed  <= malformed_s2;
			result_q.inside_res <= !malformed_s2 && !left_of_l && left_of_r;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> valid_s1)
		else $error("accepted word did not enter the input register");

	a_s1_reaches_out : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ##2 strobe)
		else $error("word in the input register produced no strobe");

	a_out_has_source : assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(valid_s1, 2))
		else $error("strobe without a word two stages back");

	a_malformed_outside : assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.malformed) |-> !result.inside_res)
		else $error("malformed quad reported a hit");
`endif

endmodule

`default_nettype wire
